// ===== rtl/core/running_histogram_median_unit_assert.svh =====
// Assertion macros for the running histogram median unit
`ifndef RUNNING_HISTOGRAM_MEDIAN_UNIT_ASSERT_SVH
`define RUNNING_HISTOGRAM_MEDIAN_UNIT_ASSERT_SVH

// Same-cycle implication, checked on clk, off while rst_n is low
`define RHM_ASSERT_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, off while rst_n is low
`define RHM_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/rhm_pkg.sv =====
// Shared types and constants of the running histogram median unit
package rhm_pkg;

  localparam int BIN_COUNT_DEF = 256;
  localparam int MAX_COUNT_DEF = 255;

  // Three color channels, in the order red, green, blue
  localparam int CHAN_N    = 3;
  localparam int CH_RED    = 0;
  localparam int CH_GREEN  = 1;
  localparam int CH_BLUE   = 2;

  localparam int PIX_W     = 8;
  localparam int ERR_W     = 2;
  localparam int ERR_RM_BIT  = 0;
  localparam int ERR_ADD_BIT = 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } rhm_state_t;

  // Per-item control seen by every channel head
  typedef struct packed {
    logic start;     // first cycle of an item: restart the running sums
    logic step;      // one bin passes the head this cycle
    logic clr;       // drop the stored bin values
    logic pend_vld;  // apply the removal left over from the previous item
    logic add_ok;    // add this item's pixel
  } rhm_ctl_t;

endpackage

// ===== rtl/core/rhm_if.sv =====
// Valid/ready channel interfaces for pixel beats in and median beats out
interface rhm_in_if import rhm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             clear_store;
  logic             add_valid;
  logic [PIX_W-1:0] add_red;
  logic [PIX_W-1:0] add_green;
  logic [PIX_W-1:0] add_blue;
  logic             emit_median;
  logic             remove_valid;
  logic [PIX_W-1:0] remove_red;
  logic [PIX_W-1:0] remove_green;
  logic [PIX_W-1:0] remove_blue;

  modport source (
    output valid, clear_store, add_valid, add_red, add_green, add_blue,
           emit_median, remove_valid, remove_red, remove_green, remove_blue,
    input  ready
  );

  modport sink (
    input  valid, clear_store, add_valid, add_red, add_green, add_blue,
           emit_median, remove_valid, remove_red, remove_green, remove_blue,
    output ready
  );
endinterface

interface rhm_out_if import rhm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] median_red;
  logic [PIX_W-1:0] median_green;
  logic [PIX_W-1:0] median_blue;
  logic             median_valid;
  logic [ERR_W-1:0] error_code;

  modport source (
    output valid, median_red, median_green, median_blue, median_valid, error_code,
    input  ready
  );

  modport sink (
    input  valid, median_red, median_green, median_blue, median_valid, error_code,
    output ready
  );
endinterface

// ===== rtl/core/running_histogram_median_unit.sv =====
// Each accepted pixel beat is handled in turn: the bin ring makes one full rotation past
// the channel heads per beat, one bin per cycle, and no new beat is accepted until the
// last one is through; a result beat still waiting on out_ch.ready holds a next beat
// that has a result of its own in its finish state until it is taken.
// Reset: control and pixel count clear at once; the bin ring holds no reset and is
// zeroed on the rotation of the first beat, so no clearing pass is needed.
`include "running_histogram_median_unit_assert.svh"

module running_histogram_median_unit import rhm_pkg::*; #(
  parameter int BIN_COUNT = BIN_COUNT_DEF,
  parameter int MAX_COUNT = MAX_COUNT_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  rhm_in_if.sink          in_ch,
  rhm_out_if.source       out_ch
);

  localparam int IDX_W = $clog2(BIN_COUNT);
  localparam int CNT_W = $clog2(MAX_COUNT + 1);
  localparam int CMP_W = ((IDX_W > PIX_W) ? IDX_W : PIX_W) + 1;

  // Map a channel value to its bin, saturating at the last bin
  function automatic logic [IDX_W-1:0] bin_of(input logic [PIX_W-1:0] v);
    logic [CMP_W-1:0] vx;
    vx = CMP_W'(v);
    if (vx >= CMP_W'(BIN_COUNT)) begin
      return IDX_W'(BIN_COUNT - 1);
    end
    return IDX_W'(v);
  endfunction

  rhm_state_t state_r, state_nxt;
  logic [IDX_W-1:0] k_r;
  logic             k_last;

  // Item registers
  logic                         clr_r;
  logic                         add_ok_r;
  logic                         add_err_r;
  logic                         emit_r;
  logic                         rm_vld_r;
  logic                         pend_use_r;
  logic [CHAN_N-1:0][IDX_W-1:0] add_idx_r;
  logic [CHAN_N-1:0][IDX_W-1:0] rm_idx_r;
  logic [CNT_W-1:0]             cnt_add_r;
  logic [CNT_W-1:0]             target_r;

  // Window state
  logic [CNT_W-1:0]             cnt_r;
  logic                         clr_pend_r;
  logic                         pend_vld_r;
  logic [CHAN_N-1:0][IDX_W-1:0] pend_idx_r;

  // Output register
  logic                         out_vld_r;
  logic [CHAN_N-1:0][PIX_W-1:0] med_out_r;
  logic                         med_vld_r;
  logic [ERR_W-1:0]             err_r;

  logic                         accept;
  logic                         step;
  logic                         fin_go;
  logic                         load_out;
  logic                         clr_eff;
  logic [CNT_W-1:0]             base_cnt;
  logic                         add_ok;
  logic [CNT_W-1:0]             cnt_add;
  logic                         rm_ok;
  logic                         rm_err;
  logic                         need_out;
  logic [CHAN_N-1:0]            zhit;
  logic [CHAN_N-1:0][PIX_W-1:0] med;
  logic [CHAN_N-1:0][CNT_W-1:0] head_val;
  rhm_ctl_t                     ctl;

  logic [CHAN_N-1:0][CNT_W-1:0] ring_q [BIN_COUNT];
  logic [CHAN_N-1:0][CNT_W-1:0] ring_d [BIN_COUNT];

  // Admission: clear, then add only while the window has room
  always_comb begin
    clr_eff  = in_ch.clear_store | clr_pend_r;
    base_cnt = clr_eff ? '0 : cnt_r;
    add_ok   = in_ch.add_valid && (base_cnt < CNT_W'(MAX_COUNT));
    cnt_add  = base_cnt + CNT_W'(add_ok);
  end

  // Removal check after the scan has seen every addressed bin
  always_comb begin
    rm_ok    = rm_vld_r && (cnt_add_r != '0) && !(|zhit);
    rm_err   = rm_vld_r && !rm_ok;
    need_out = emit_r || add_err_r || rm_err;
  end

  assign k_last = (k_r == IDX_W'(BIN_COUNT - 1));

  // Hold the state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequence one beat: accept, rotate the ring once, deliver
  always_comb begin
    state_nxt = state_r;
    accept    = 1'b0;
    step      = 1'b0;
    fin_go    = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid && rst_n) begin
          accept    = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        step = 1'b1;
        if (k_last) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!need_out || !out_vld_r || out_ch.ready) begin
          fin_go    = 1'b1;
          load_out  = need_out;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_ch.ready = (state_r == ST_IDLE) && rst_n;

  // Advance the bin index at the ring head
  always_ff @(posedge clk) begin
    if (accept) begin
      k_r <= '0;
    end else if (step && !k_last) begin
      k_r <= k_r + IDX_W'(1);
    end
  end

  // Capture the beat
  always_ff @(posedge clk) begin
    if (accept) begin
      clr_r      <= clr_eff;
      add_ok_r   <= add_ok;
      add_err_r  <= in_ch.add_valid && !add_ok;
      emit_r     <= in_ch.emit_median;
      rm_vld_r   <= in_ch.remove_valid;
      pend_use_r <= pend_vld_r && !clr_eff;
      add_idx_r[CH_RED]   <= bin_of(in_ch.add_red);
      add_idx_r[CH_GREEN] <= bin_of(in_ch.add_green);
      add_idx_r[CH_BLUE]  <= bin_of(in_ch.add_blue);
      rm_idx_r[CH_RED]    <= bin_of(in_ch.remove_red);
      rm_idx_r[CH_GREEN]  <= bin_of(in_ch.remove_green);
      rm_idx_r[CH_BLUE]   <= bin_of(in_ch.remove_blue);
      cnt_add_r  <= cnt_add;
      target_r   <= (cnt_add >> 1) + CNT_W'(1);
    end
  end

  // Commit the count; defer an accepted removal to the next rotation
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      clr_pend_r <= 1'b1;
      pend_vld_r <= 1'b0;
    end else if (fin_go) begin
      cnt_r      <= cnt_add_r - CNT_W'(rm_ok);
      clr_pend_r <= 1'b0;
      pend_vld_r <= rm_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go && rm_ok) begin
      pend_idx_r <= rm_idx_r;
    end
  end

  // Drive the result beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (load_out) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      med_out_r <= emit_r ? med : '0;
      med_vld_r <= emit_r;
      err_r[ERR_RM_BIT]  <= rm_err;
      err_r[ERR_ADD_BIT] <= add_err_r;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.median_red   = med_out_r[CH_RED];
  assign out_ch.median_green = med_out_r[CH_GREEN];
  assign out_ch.median_blue  = med_out_r[CH_BLUE];
  assign out_ch.median_valid = med_vld_r;
  assign out_ch.error_code   = err_r;

  always_comb begin
    ctl.start    = accept;
    ctl.step     = step;
    ctl.clr      = clr_r;
    ctl.pend_vld = pend_use_r;
    ctl.add_ok   = add_ok_r;
  end

  // Channel heads at cell 0 of the ring
  for (genvar c = 0; c < CHAN_N; c++) begin : g_chan
    rhm_chan #(
      .IDX_W (IDX_W),
      .CNT_W (CNT_W)
    ) u_chan (
      .clk      (clk),
      .ctl      (ctl),
      .bin_idx  (k_r),
      .target   (target_r),
      .pend_idx (pend_idx_r[c]),
      .add_idx  (add_idx_r[c]),
      .rm_idx   (rm_idx_r[c]),
      .bin_in   (ring_q[0][c]),
      .bin_out  (head_val[c]),
      .median   (med[c]),
      .zero_hit (zhit[c])
    );
  end

  // Ring of bin cells: each takes its upper neighbor, the last takes the head
  for (genvar i = 0; i < BIN_COUNT; i++) begin : g_ring
    if (i == BIN_COUNT - 1) begin : g_tail
      assign ring_d[i] = head_val;
    end else begin : g_link
      assign ring_d[i] = ring_q[i+1];
    end

    rhm_cell #(
      .CNT_W (CNT_W)
    ) u_cell (
      .clk      (clk),
      .shift_en (step),
      .d        (ring_d[i]),
      .q        (ring_q[i])
    );
  end

  // Checks
  `RHM_ASSERT_NEXT(a_accept_starts_scan, in_ch.valid && in_ch.ready,
    (state_r == ST_SCAN) && (k_r == '0), "accepted beat did not start a scan at bin 0")
  `RHM_ASSERT_NEXT(a_scan_ends, (state_r == ST_SCAN) && k_last,
    state_r == ST_FIN, "scan did not end after the last bin")
  `RHM_ASSERT_IMPLY(a_result_has_cause, out_ch.valid && !out_ch.median_valid,
    (out_ch.error_code != '0) && (out_ch.median_red == '0) &&
    (out_ch.median_green == '0) && (out_ch.median_blue == '0),
    "result beat without a median request or an error")
  `RHM_ASSERT_IMPLY(a_count_limit, 1'b1, cnt_r <= CNT_W'(MAX_COUNT),
    "pixel count exceeds its limit")

endmodule

// ===== rtl/core/rhm_cell.sv =====
// One ring cell: holds the red, green and blue counts of one bin
module rhm_cell import rhm_pkg::*; #(
  parameter int CNT_W = 8
) (
  input  logic                         clk,
  input  logic                         shift_en,
  input  logic [CHAN_N-1:0][CNT_W-1:0] d,
  output logic [CHAN_N-1:0][CNT_W-1:0] q
);

  logic [CHAN_N-1:0][CNT_W-1:0] bins_r;

  // Take the neighbor's counts on every rotation step
  always_ff @(posedge clk) begin
    if (shift_en) begin
      bins_r <= d;
    end
  end

  assign q = bins_r;

endmodule

// ===== rtl/core/rhm_chan.sv =====
// Channel head: updates the bin at the ring head and runs the median search
module rhm_chan import rhm_pkg::*; #(
  parameter int IDX_W = 8,
  parameter int CNT_W = 8
) (
  input  logic             clk,
  input  rhm_ctl_t         ctl,
  input  logic [IDX_W-1:0] bin_idx,
  input  logic [CNT_W-1:0] target,
  input  logic [IDX_W-1:0] pend_idx,
  input  logic [IDX_W-1:0] add_idx,
  input  logic [IDX_W-1:0] rm_idx,
  input  logic [CNT_W-1:0] bin_in,
  output logic [CNT_W-1:0] bin_out,
  output logic [PIX_W-1:0] median,
  output logic             zero_hit
);

  logic [CNT_W-1:0] sum_r;
  logic             found_r;
  logic [PIX_W-1:0] med_r;
  logic             zhit_r;

  logic [CNT_W-1:0] v_clr;
  logic [CNT_W-1:0] v_rm;
  logic [CNT_W-1:0] v_add;
  logic [CNT_W-1:0] sum_nxt;
  logic             hit;

  // Clear, take off the deferred removal, then add the new pixel
  always_comb begin
    v_clr   = ctl.clr ? '0 : bin_in;
    v_rm    = v_clr - CNT_W'(ctl.pend_vld && (bin_idx == pend_idx));
    v_add   = v_rm + CNT_W'(ctl.add_ok && (bin_idx == add_idx));
    sum_nxt = sum_r + v_add;
    hit     = !found_r && (sum_nxt >= target);
  end

  assign bin_out = v_add;

  // Accumulate the running sum and latch the first bin that reaches the target
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      sum_r   <= '0;
      found_r <= 1'b0;
      med_r   <= '0;
      zhit_r  <= 1'b0;
    end else if (ctl.step) begin
      sum_r  <= sum_nxt;
      zhit_r <= zhit_r | ((bin_idx == rm_idx) && (v_add == '0));
      if (hit) begin
        found_r <= 1'b1;
        med_r   <= PIX_W'(bin_idx);
      end
    end
  end

  assign median   = med_r;
  assign zero_hit = zhit_r;

endmodule

// ===== tb/tb_running_histogram_median_unit.sv =====
// Testbench for running_histogram_median_unit: directed and random sliding-window pixel beats
module tb_running_histogram_median_unit;
  import rhm_pkg::*;

  localparam int BINS         = BIN_COUNT_DEF;
  localparam int WIN_MAX      = MAX_COUNT_DEF;
  localparam int BEAT_CYCLES  = BINS + 2;
  localparam int QUIET_LIMIT  = 12 * BEAT_CYCLES;
  localparam int DRAIN_CYCLES = 2 * BEAT_CYCLES + 40;
  localparam int RANDOM_BEATS = 1500;
  localparam int MAX_REPORTS  = 200;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic clear;
    logic add_v;
    rgb_t add_px;
    logic emit;
    logic rm_v;
    rgb_t rm_px;
  } pix_beat_t;

  typedef struct packed {
    rgb_t             med;
    logic             med_valid;
    logic [ERR_W-1:0] err;
  } median_beat_t;

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_THREE_OF_FOUR,
    RDY_COIN,
    RDY_RARE
  } rdy_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rhm_in_if  in_if ();
  rhm_out_if out_if ();

  running_histogram_median_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  always #6 clk = ~clk;

  // Window histograms as the block should hold them
  int unsigned hist [CHAN_N][BINS];
  int unsigned win_pixels;

  pix_beat_t    pixel_beats_todo [$];
  median_beat_t median_beats_due [$];
  rgb_t         gen_win [$];

  int beats_total;
  int beats_accepted;
  int fail_count;
  int report_count;
  int quiet_cycles;

  function automatic rgb_t px(int r, int g, int b);
    rgb_t p;
    p.red   = r[PIX_W-1:0];
    p.green = g[PIX_W-1:0];
    p.blue  = b[PIX_W-1:0];
    return p;
  endfunction

  function automatic pix_beat_t mk_beat(bit clr, bit av, rgb_t ap, bit em, bit rv, rgb_t rp);
    pix_beat_t b;
    b.clear  = clr;
    b.add_v  = av;
    b.add_px = ap;
    b.emit   = em;
    b.rm_v   = rv;
    b.rm_px  = rp;
    return b;
  endfunction

  // Pick one pixel; with ends set each channel is either lo or hi
  function automatic rgb_t rand_px(int lo, int hi, bit ends);
    if (ends)
      return px($urandom_range(0, 1) ? hi : lo, $urandom_range(0, 1) ? hi : lo,
                $urandom_range(0, 1) ? hi : lo);
    return px($urandom_range(lo, hi), $urandom_range(lo, hi), $urandom_range(lo, hi));
  endfunction

  // Saturate a channel value onto the last bin
  function automatic int bin_of(logic [PIX_W-1:0] v);
    return (int'(v) >= BINS) ? BINS - 1 : int'(v);
  endfunction

  // First bin whose running sum reaches half the window plus one
  function automatic logic [PIX_W-1:0] hist_median(int ch);
    int unsigned want_sum;
    int unsigned run_sum;
    want_sum = win_pixels / 2 + 1;
    run_sum  = 0;
    for (int i = 0; i < BINS; i++) begin
      run_sum += hist[ch][i];
      if (run_sum >= want_sum) return i[PIX_W-1:0];
    end
    return '0;
  endfunction

  // Update the histograms for one accepted beat and queue its median beat, if any
  task automatic apply_pixel_beat(input pix_beat_t b);
    median_beat_t r;
    int rb;
    int gb;
    int bb;
    r = '0;
    if (b.clear) begin
      for (int c = 0; c < CHAN_N; c++)
        for (int i = 0; i < BINS; i++) hist[c][i] = 0;
      win_pixels = 0;
    end
    if (b.add_v) begin
      if (win_pixels >= WIN_MAX) begin
        r.err[ERR_ADD_BIT] = 1'b1;
      end else begin
        hist[CH_RED][bin_of(b.add_px.red)]++;
        hist[CH_GREEN][bin_of(b.add_px.green)]++;
        hist[CH_BLUE][bin_of(b.add_px.blue)]++;
        win_pixels++;
      end
    end
    if (b.emit) begin
      r.med.red   = hist_median(CH_RED);
      r.med.green = hist_median(CH_GREEN);
      r.med.blue  = hist_median(CH_BLUE);
      r.med_valid = 1'b1;
    end
    if (b.rm_v) begin
      rb = bin_of(b.rm_px.red);
      gb = bin_of(b.rm_px.green);
      bb = bin_of(b.rm_px.blue);
      if (win_pixels == 0 || hist[CH_RED][rb] == 0 || hist[CH_GREEN][gb] == 0 ||
          hist[CH_BLUE][bb] == 0) begin
        r.err[ERR_RM_BIT] = 1'b1;
      end else begin
        hist[CH_RED][rb]--;
        hist[CH_GREEN][gb]--;
        hist[CH_BLUE][bb]--;
        win_pixels--;
      end
    end
    if (b.emit || r.err != '0) median_beats_due.push_back(r);
  endtask

  // Queue a beat and track the window roughly, so later removals can name real pixels
  task automatic push_beat(input pix_beat_t b);
    if (b.clear) gen_win.delete();
    if (b.add_v && gen_win.size() < WIN_MAX) gen_win.push_back(b.add_px);
    if (b.rm_v) begin
      for (int i = 0; i < gen_win.size(); i++) begin
        if (gen_win[i] == b.rm_px) begin
          gen_win.delete(i);
          break;
        end
      end
    end
    pixel_beats_todo.push_back(b);
  endtask

  // Fill a window, then slide it: add a pixel, ask for the median, drop the oldest
  task automatic queue_slide(input bit broken);
    int lo;
    int hi;
    int fill_n;
    int slide_n;
    bit ends;
    bit fresh;
    bit av;
    bit rv;
    rgb_t rp;
    ends = 1'b0;
    case ($urandom_range(0, 2))
      0: begin
        lo = 0;
        hi = 255;
      end
      1: begin
        lo = $urandom_range(0, 248);
        hi = lo + 7;
      end
      default: begin
        lo   = 0;
        hi   = 255;
        ends = 1'b1;
      end
    endcase
    fill_n  = ($urandom_range(0, 7) == 0) ? $urandom_range(26, 81) : $urandom_range(1, 25);
    slide_n = $urandom_range(4, 40);
    fresh   = ($urandom_range(0, 4) != 0);
    for (int i = 0; i < fill_n; i++)
      push_beat(mk_beat(fresh && i == 0, 1'b1, rand_px(lo, hi, ends),
                        $urandom_range(0, 3) == 0, 1'b0, px(0, 0, 0)));
    for (int i = 0; i < slide_n; i++) begin
      av = ($urandom_range(0, 9) != 0);
      rv = ($urandom_range(0, 9) != 0);
      if (broken && $urandom_range(0, 2) == 0) begin
        rp = rand_px(0, 255, 1'b0);
      end else if (gen_win.size() > 0) begin
        rp = gen_win[0];
      end else begin
        rp = px(0, 0, 0);
        rv = 1'b0;
      end
      push_beat(mk_beat(1'b0, av, rand_px(lo, hi, ends), $urandom_range(0, 9) != 0, rv, rp));
    end
  endtask

  // Fully random beats
  task automatic queue_noise();
    int n;
    n = $urandom_range(3, 12);
    for (int i = 0; i < n; i++)
      push_beat(mk_beat(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                        rand_px(0, 255, 1'b0), 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)), rand_px(0, 255, 1'b0)));
  endtask

  // Fill the window to its limit, then push adds and removals against the full window
  task automatic queue_full_window();
    push_beat(mk_beat(1'b1, 1'b1, rand_px(0, 100, 1'b0), 1'b0, 1'b0, px(0, 0, 0)));
    for (int i = 1; i < WIN_MAX; i++)
      push_beat(mk_beat(1'b0, 1'b1, rand_px(0, 100, 1'b0), i % 64 == 0, 1'b0, px(0, 0, 0)));
    push_beat(mk_beat(1'b0, 1'b1, rand_px(0, 100, 1'b0), 1'b1, 1'b0, px(0, 0, 0)));
    push_beat(mk_beat(1'b0, 1'b1, rand_px(0, 100, 1'b0), 1'b0, 1'b1, px(200, 200, 200)));
    push_beat(mk_beat(1'b0, 1'b0, px(0, 0, 0), 1'b1, 1'b1, gen_win[0]));
    push_beat(mk_beat(1'b0, 1'b1, rand_px(0, 100, 1'b0), 1'b1, 1'b0, px(0, 0, 0)));
    push_beat(mk_beat(1'b0, 1'b1, rand_px(0, 100, 1'b0), 1'b1, 1'b1, gen_win[0]));
  endtask

  task automatic note_field(string name, int want, int got);
    fail_count++;
    if (report_count < MAX_REPORTS) begin
      report_count++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  // Stimulus and end of run
  initial begin : stimulus
    int seq_n;
    int r;

    // Directed: empty window, removal from empty, extremes, clears, ties and mixed removals
    push_beat(mk_beat(0, 0, px(0, 0, 0), 1, 0, px(0, 0, 0)));
    push_beat(mk_beat(0, 0, px(0, 0, 0), 1, 1, px(0, 0, 0)));
    push_beat(mk_beat(0, 0, px(0, 0, 0), 0, 1, px(255, 255, 255)));
    push_beat(mk_beat(0, 1, px(0, 0, 0), 0, 0, px(0, 0, 0)));
    push_beat(mk_beat(0, 1, px(255, 255, 255), 1, 0, px(0, 0, 0)));
    push_beat(mk_beat(0, 0, px(0, 0, 0), 1, 1, px(0, 255, 0)));
    push_beat(mk_beat(0, 0, px(0, 0, 0), 1, 1, px(0, 0, 0)));
    push_beat(mk_beat(1, 0, px(0, 0, 0), 1, 0, px(0, 0, 0)));
    push_beat(mk_beat(1, 1, px(10, 20, 30), 1, 1, px(10, 20, 30)));
    push_beat(mk_beat(0, 1, px(5, 200, 128), 1, 1, px(99, 99, 99)));
    push_beat(mk_beat(1, 1, px(255, 255, 255), 1, 1, px(255, 255, 255)));
    push_beat(mk_beat(1, 0, px(0, 0, 0), 0, 0, px(0, 0, 0)));
    for (int i = 1; i <= 4; i++)
      push_beat(mk_beat(0, 1, px(i, i, i), i == 4, 0, px(0, 0, 0)));
    push_beat(mk_beat(0, 1, px(0, 128, 255), 1, 0, px(0, 0, 0)));
    push_beat(mk_beat(0, 0, px(0, 0, 0), 1, 1, px(1, 2, 3)));
    push_beat(mk_beat(0, 1, px(170, 85, 15), 1, 1, px(4, 4, 4)));
    push_beat(mk_beat(0, 0, px(0, 0, 0), 0, 0, px(0, 0, 0)));
    push_beat(mk_beat(1, 1, px(128, 127, 1), 0, 1, px(128, 127, 1)));
    push_beat(mk_beat(0, 0, px(0, 0, 0), 1, 0, px(0, 0, 0)));

    // Random: mostly well-formed sliding windows, some broken ones and noise
    seq_n = 0;
    r     = 0;
    while (pixel_beats_todo.size() < 22 + RANDOM_BEATS) begin
      r = $urandom_range(0, 99);
      if (seq_n == 2 || r < 3) queue_full_window();
      else if (r < 75) queue_slide(1'b0);
      else if (r < 88) queue_slide(1'b1);
      else queue_noise();
      seq_n++;
    end
    beats_total = pixel_beats_todo.size();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (beats_accepted < beats_total || median_beats_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Driver: send beats in bursts with random gaps
  always @(posedge clk) begin : driver
    pix_beat_t nxt;
    pix_beat_t on_bus;
    int burst_left;
    int gap_left;
    if (!rst_n) begin
      in_if.valid        <= 1'b0;
      in_if.clear_store  <= 1'b0;
      in_if.add_valid    <= 1'b0;
      in_if.add_red      <= '0;
      in_if.add_green    <= '0;
      in_if.add_blue     <= '0;
      in_if.emit_median  <= 1'b0;
      in_if.remove_valid <= 1'b0;
      in_if.remove_red   <= '0;
      in_if.remove_green <= '0;
      in_if.remove_blue  <= '0;
      burst_left = $urandom_range(1, 8);
      gap_left   = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        apply_pixel_beat(on_bus);
        beats_accepted++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (pixel_beats_todo.size() > 0) begin
          nxt    = pixel_beats_todo.pop_front();
          on_bus = nxt;
          in_if.valid        <= 1'b1;
          in_if.clear_store  <= nxt.clear;
          in_if.add_valid    <= nxt.add_v;
          in_if.add_red      <= nxt.add_px.red;
          in_if.add_green    <= nxt.add_px.green;
          in_if.add_blue     <= nxt.add_px.blue;
          in_if.emit_median  <= nxt.emit;
          in_if.remove_valid <= nxt.rm_v;
          in_if.remove_red   <= nxt.rm_px.red;
          in_if.remove_green <= nxt.rm_px.green;
          in_if.remove_blue  <= nxt.rm_px.blue;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each median beat against the oldest one due, stall on a shifting pattern
  always @(posedge clk) begin : monitor
    median_beat_t got;
    median_beat_t want;
    rdy_mode_t rdy_mode;
    int mode_left;
    int tick;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      rdy_mode  = RDY_ALWAYS;
      mode_left = 0;
      tick      = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got.med.red   = out_if.median_red;
        got.med.green = out_if.median_green;
        got.med.blue  = out_if.median_blue;
        got.med_valid = out_if.median_valid;
        got.err       = out_if.error_code;
        if (median_beats_due.size() == 0) begin
          fail_count++;
          if (report_count < MAX_REPORTS) begin
            report_count++;
            $display("%0t: no beat expected, actual median %0d/%0d/%0d valid %0d err %0d",
                     $time, got.med.red, got.med.green, got.med.blue, got.med_valid, got.err);
          end
        end else begin
          want = median_beats_due.pop_front();
          if (got.med.red != want.med.red)
            note_field("median_red", want.med.red, got.med.red);
          if (got.med.green != want.med.green)
            note_field("median_green", want.med.green, got.med.green);
          if (got.med.blue != want.med.blue)
            note_field("median_blue", want.med.blue, got.med.blue);
          if (got.med_valid != want.med_valid)
            note_field("median_valid", want.med_valid, got.med_valid);
          if (got.err != want.err)
            note_field("error_code", want.err, got.err);
        end
      end
      // Switch the stall pattern now and then
      if (mode_left == 0) begin
        rdy_mode  = rdy_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(200, 1200);
      end else begin
        mode_left--;
      end
      tick++;
      case (rdy_mode)
        RDY_ALWAYS:        out_if.ready <= 1'b1;
        RDY_THREE_OF_FOUR: out_if.ready <= (tick % 4 != 0);
        RDY_COIN:          out_if.ready <= 1'($urandom_range(0, 1));
        default:           out_if.ready <= (tick % 6 == 0);
      endcase
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// ===== running_histogram_median_unit.f =====
+incdir+rtl/core
rtl/core/rhm_pkg.sv
rtl/core/rhm_if.sv
rtl/core/rhm_cell.sv
rtl/core/rhm_chan.sv
rtl/core/running_histogram_median_unit.sv
tb/tb_running_histogram_median_unit.sv
